[design/smx_pkg.sv]
// Package with shared types, tables and fixed-point helpers for the softmax unit.
package smx_pkg;

  typedef struct packed {
    logic signed [15:0] score;
    logic               final_element;
  } smx_in_t;

  typedef struct packed {
    logic [15:0] probability;
    logic        last_of_run;
    logic        overflowed;
  } smx_out_t;

  // Table of 2^(-h/16) in Q.16, indexed by bits [7:4] of the Q.8 log2 product.
  function automatic logic [16:0] pow_hi(input logic [3:0] h);
    case (h)
      4'd0:    pow_hi = 17'd65536;
      4'd1:    pow_hi = 17'd62757;
      4'd2:    pow_hi = 17'd60097;
      4'd3:    pow_hi = 17'd57549;
      4'd4:    pow_hi = 17'd55109;
      4'd5:    pow_hi = 17'd52773;
      4'd6:    pow_hi = 17'd50535;
      4'd7:    pow_hi = 17'd48393;
      4'd8:    pow_hi = 17'd46341;
      4'd9:    pow_hi = 17'd44376;
      4'd10:   pow_hi = 17'd42495;
      4'd11:   pow_hi = 17'd40693;
      4'd12:   pow_hi = 17'd38968;
      4'd13:   pow_hi = 17'd37316;
      4'd14:   pow_hi = 17'd35734;
      default: pow_hi = 17'd34219;
    endcase
  endfunction

  function automatic logic [16:0] pow_lo(input logic [3:0] l);
    case (l)
      4'd0:    pow_lo = 17'd65536;
      4'd1:    pow_lo = 17'd65359;
      4'd2:    pow_lo = 17'd65182;
      4'd3:    pow_lo = 17'd65006;
      4'd4:    pow_lo = 17'd64830;
      4'd5:    pow_lo = 17'd64655;
      4'd6:    pow_lo = 17'd64480;
      4'd7:    pow_lo = 17'd64306;
      4'd8:    pow_lo = 17'd64132;
      4'd9:    pow_lo = 17'd63958;
      4'd10:   pow_lo = 17'd63785;
      4'd11:   pow_lo = 17'd63613;
      4'd12:   pow_lo = 17'd63441;
      4'd13:   pow_lo = 17'd63269;
      4'd14:   pow_lo = 17'd63098;
      default: pow_lo = 17'd62928;
    endcase
  endfunction

  function automatic logic [15:0] log_tab(input logic [4:0] i);
    case (i)
      5'd0:    log_tab = 16'd0;
      5'd1:    log_tab = 16'd3973;
      5'd2:    log_tab = 16'd7719;
      5'd3:    log_tab = 16'd11262;
      5'd4:    log_tab = 16'd14624;
      5'd5:    log_tab = 16'd17821;
      5'd6:    log_tab = 16'd20870;
      5'd7:    log_tab = 16'd23783;
      5'd8:    log_tab = 16'd26573;
      5'd9:    log_tab = 16'd29248;
      5'd10:   log_tab = 16'd31818;
      5'd11:   log_tab = 16'd34292;
      5'd12:   log_tab = 16'd36675;
      5'd13:   log_tab = 16'd38975;
      5'd14:   log_tab = 16'd41196;
      5'd15:   log_tab = 16'd43345;
      default: log_tab = 16'd45426;
    endcase
  endfunction

  localparam logic [16:0] Log2E   = 17'd94548;
  localparam logic [15:0] Ln2     = 16'd45426;

endpackage

[design/softmax_vector_unit.sv]
// Top level of the softmax unit: element store, sequencer and output register.
//
//  channel | direction | payload     | handshake
//  in      | input     | smx_in_t    | in_valid_i / in_stall_o
//  out     | output    | smx_out_t   | out_valid_o / out_stall_i
//
// Loading takes one cycle per element; the block stays ready while a vector fills.
// On the final element the sum pass streams every stored element through the shared
// three-stage exp unit, and the log unit then runs on the sum. The output pass then
// sends each element alone through the exp unit, so a new read waits until the last
// result has left it; an output stall also holds back the next read.
// Reset clears all control state; the store needs no clearing.
// The input is stalled from the final element until the last probability is presented.
module softmax_vector_unit import smx_pkg::*; #(
  parameter int VECTOR_DEPTH = 64
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  smx_in_t  in_data_i,
  output logic     out_valid_o,
  input  logic     out_stall_i,
  output smx_out_t out_data_o
);
  localparam int AW = $clog2(VECTOR_DEPTH);
  localparam int CW = $clog2(VECTOR_DEPTH + 1);

  typedef enum logic [2:0] {Load, SumIss, SumWait, LnRun, OutIss} state_e;

  state_e state_q;
  logic signed [15:0] store [VECTOR_DEPTH];
  logic [CW-1:0] count_q, rd_q, ret_q;
  logic signed [15:0] max_q;
  logic [31:0] sum_q;
  logic drop_q;
  logic signed [15:0] rd_data_q;
  logic [3:0] vld_q;           // pipeline of valid reads into exp (read + 3 stages)
  logic signed [24:0] c_q;
  logic [17:0] u;
  logic [16:0] v;
  logic ln_start, ln_done;
  logic [15:0] ln_val;
  logic signed [25:0] d;
  logic in_acc, rd_en, room;

  assign in_stall_o = (state_q != Load);
  assign in_acc = in_valid_i && !in_stall_o;

  // In the output pass a read is issued only when the result can be absorbed.
  assign room  = !out_valid_o || !out_stall_i;
  assign rd_en = (state_q == SumIss) ? (rd_q < count_q)
               : (state_q == OutIss) ? (rd_q < count_q) && room && (vld_q == 4'd0)
               : 1'b0;

  always_ff @(posedge clk_i) begin
    if (in_acc && (count_q < CW'(VECTOR_DEPTH))) store[count_q[AW-1:0]] <= in_data_i.score;
    rd_data_q <= store[rd_q[AW-1:0]];
  end

  always_comb begin
    if (state_q == OutIss) begin
      d = 26'(c_q) - 26'(rd_data_q);
      u = (d > 0) ? ((d > 26'sd262143) ? 18'h3FFFF : 18'(d)) : 18'd0;
    end else begin
      d = '0;
      u = 18'($signed({max_q[15], max_q}) - $signed({rd_data_q[15], rd_data_q}));
    end
  end

  smx_exp u_exp (.clk_i, .u_i(u), .v_o(v));

  assign ln_start = (state_q == SumWait) && (vld_q == 4'd0);
  smx_ln u_ln (.clk_i, .rst_ni, .start_i(ln_start), .sum_i(sum_q),
               .done_o(ln_done), .ln_o(ln_val));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= Load;
      count_q     <= '0;
      max_q       <= 16'sh8000;
      sum_q       <= '0;
      drop_q      <= 1'b0;
      rd_q        <= '0;
      ret_q       <= '0;
      vld_q       <= '0;
      c_q         <= '0;
      out_valid_o <= 1'b0;
      out_data_o  <= '0;
    end else begin
      vld_q <= {vld_q[2:0], rd_en};
      if (rd_en) rd_q <= rd_q + CW'(1);
      if (out_valid_o && !out_stall_i) out_valid_o <= 1'b0;
      case (state_q)
        Load: if (in_acc) begin
          if (count_q < CW'(VECTOR_DEPTH)) begin
            count_q <= count_q + CW'(1);
            if (in_data_i.score > max_q) max_q <= in_data_i.score;
          end else begin
            drop_q <= 1'b1;
          end
          if (in_data_i.final_element) begin
            rd_q    <= '0;
            sum_q   <= '0;
            state_q <= SumIss;
          end
        end
        SumIss: begin
          if (vld_q[3]) sum_q <= sum_q + 32'(v);
          if (!rd_en) state_q <= SumWait;
        end
        SumWait: begin
          if (vld_q[3]) sum_q <= sum_q + 32'(v);
          if (vld_q == 4'd0) state_q <= LnRun;
        end
        LnRun: if (ln_done) begin
          c_q     <= 25'(max_q) + 25'(ln_val);
          rd_q    <= '0;
          ret_q   <= '0;
          state_q <= OutIss;
        end
        OutIss: begin
          if (vld_q[3]) begin
            out_valid_o <= 1'b1;
            out_data_o.probability <= (v > 17'd65535) ? 16'hFFFF : v[15:0];
            out_data_o.last_of_run <= (ret_q + CW'(1) == count_q);
            out_data_o.overflowed  <= drop_q;
            ret_q <= ret_q + CW'(1);
            if (ret_q + CW'(1) == count_q) begin
              state_q <= Load;
              count_q <= '0;
              max_q   <= 16'sh8000;
              drop_q  <= 1'b0;
            end
          end
        end
        default: state_q <= Load;
      endcase
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(VECTOR_DEPTH)) else $error("element count beyond depth");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == Load) |-> (vld_q == 4'd0)) else $error("exp pipe busy while loading");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> out_valid_o) else $error("result dropped");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ln_done |-> (state_q == LnRun)) else $error("log result out of phase");
endmodule

[design/smx_exp.sv]
// Shared three-stage exp(-u) unit: scale by log2(e), table product, shift.
module smx_exp import smx_pkg::*; (
  input  logic        clk_i,
  input  logic [17:0] u_i,
  output logic [16:0] v_o
);
  // Stage 1: t = round(u * log2 e) in Q.8.
  logic [35:0] prod1;
  logic [19:0] t_q;
  // Stage 2: table product.
  logic [33:0] prod2;
  logic [16:0] m_q;
  logic [11:0] k_q;

  assign prod1 = 36'(u_i) * 36'(Log2E) + 36'd32768;
  assign prod2 = 34'(pow_hi(t_q[7:4])) * 34'(pow_lo(t_q[3:0])) + 34'd32768;

  always_ff @(posedge clk_i) begin
    t_q <= prod1[35:16];
    m_q <= prod2[32:16];
    k_q <= t_q[19:8];
    v_o <= (k_q >= 12'd17) ? 17'd0 : (m_q >> k_q[4:0]);
  end
endmodule

[design/smx_ln.sv]
// Iterative natural-log unit: one normalizing shift per cycle, then table interpolation.
module smx_ln import smx_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [31:0] sum_i,
  output logic        done_o,
  output logic [15:0] ln_o
);
  typedef enum logic [1:0] {LnIdle, LnNorm, LnMul, LnOut} ln_state_e;
  ln_state_e   state_q;
  logic [31:0] s_q;
  logic [4:0]  e_q;
  logic [24:0] acc_q;
  logic [16:0] f;
  logic [4:0]  i;
  logic [15:0] diff;
  logic [28:0] interp;

  assign f      = 17'(s_q[16:0] - 17'd65536);
  assign i      = {1'b0, f[15:12]};
  assign diff   = log_tab(5'(i + 5'd1)) - log_tab(i);
  assign interp = 29'(diff) * 29'(f[11:0]) + 29'd2048;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= LnIdle;
      done_o  <= 1'b0;
      s_q     <= '0;
      e_q     <= '0;
      acc_q   <= '0;
      ln_o    <= '0;
    end else begin
      done_o <= 1'b0;
      case (state_q)
        LnIdle: if (start_i) begin
          s_q <= sum_i;
          e_q <= '0;
          state_q <= LnNorm;
        end
        LnNorm: begin
          if (s_q >= 32'd131072) begin
            s_q <= s_q >> 1;
            e_q <= e_q + 5'd1;
          end else begin
            acc_q   <= 25'(e_q) * 25'(Ln2);
            state_q <= LnMul;
          end
        end
        LnMul: begin
          acc_q   <= acc_q + 25'(log_tab(i)) + 25'(interp[28:12]);
          state_q <= LnOut;
        end
        LnOut: begin
          ln_o    <= 16'((acc_q + 25'd128) >> 8);
          done_o  <= 1'b1;
          state_q <= LnIdle;
        end
        default: state_q <= LnIdle;
      endcase
    end
  end
endmodule

[tb/tb_softmax_vector_unit.sv]
// Self-checking testbench for the softmax vector unit: table-driven directed vectors, then random vectors.
`timescale 1ns / 100ps

module tb_softmax_vector_unit;
  import smx_pkg::*;

  localparam int Depth = 64;

  logic     clk_i = 1'b0;
  logic     rst_ni = 1'b0;
  logic     in_valid_i = 1'b0;
  logic     in_stall_o;
  smx_in_t  in_data_i = '0;
  logic     out_valid_o;
  logic     out_stall_i = 1'b0;
  smx_out_t out_data_o;

  softmax_vector_unit #(.VECTOR_DEPTH(Depth)) dut (.*);

  always #1 clk_i = ~clk_i;

  // Copy of the block's state, kept by the predictor.
  logic signed [15:0] held_scores[Depth];
  int                 held_fixed[Depth];
  int unsigned        held_count;
  logic signed [15:0] peak_score;
  bit                 lost_flag;

  smx_out_t    pending_probs[$];
  int unsigned mismatches;
  int unsigned probs_seen;
  int unsigned vectors_sent;
  int          sender_idle_pct;
  int          receiver_idle_pct;

  // Expected-value override for directed rows: -1 means use the predictor.
  typedef struct {
    logic signed [15:0] score;
    bit                 fin;
    int                 fixed_prob;
  } stim_row_t;

  localparam int unsigned HiTab[16] = '{65536, 62757, 60097, 57549, 55109, 52773, 50535,
    48393, 46341, 44376, 42495, 40693, 38968, 37316, 35734, 34219};
  localparam int unsigned LoTab[16] = '{65536, 65359, 65182, 65006, 64830, 64655, 64480,
    64306, 64132, 63958, 63785, 63613, 63441, 63269, 63098, 62928};
  localparam int LnTab[17] = '{0, 3973, 7719, 11262, 14624, 17821, 20870, 23783, 26573,
    29248, 31818, 34292, 36675, 38975, 41196, 43345, 45426};

  // exp(-u/256) in Q.16 via base-2 split.
  function automatic longint unsigned exp_of_neg(longint unsigned u);
    longint unsigned t, k, v;
    t = (u * 94548 + 32768) >> 16;
    k = t >> 8;
    if (k >= 17) return 0;
    v = (longint'(HiTab[(t >> 4) & 15]) * LoTab[t & 15] + 32768) >> 16;
    return v >> k;
  endfunction

  // Natural log of a Q.16 sum, rounded to Q.8.
  function automatic longint ln_of_sum(longint unsigned s);
    int unsigned e, f, i, r;
    longint ln;
    e = 0;
    if (s < 65536) return 0;
    while ((s >> e) >= 131072) e++;
    f = int'((s >> e) - 65536);
    i = (f >> 12) & 15;
    r = f & 4095;
    ln = longint'(e) * 45426 + LnTab[i]
       + ((longint'(LnTab[i + 1] - LnTab[i]) * r + 2048) >>> 12);
    return (ln + 128) >>> 8;
  endfunction

  // Absorb one element; on the final one queue every probability of the vector.
  task automatic predict_softmax(input smx_in_t item, input int fixed_prob);
    longint unsigned sum, p;
    longint shift_c, d;
    smx_out_t r;
    if (held_count < Depth) begin
      held_scores[held_count] = item.score;
      held_fixed[held_count]  = fixed_prob;
      held_count++;
      if (item.score > peak_score) peak_score = item.score;
    end else begin
      lost_flag = 1'b1;
    end
    if (!item.final_element) return;
    sum = 0;
    for (int j = 0; j < held_count; j++)
      sum = (sum + exp_of_neg(longint'(peak_score) - held_scores[j])) & 32'hFFFF_FFFF;
    shift_c = longint'(peak_score) + ln_of_sum(sum);
    for (int j = 0; j < held_count; j++) begin
      d = shift_c - held_scores[j];
      p = exp_of_neg(d > 0 ? d : 0);
      if (p > 65535) p = 65535;
      r.probability = (held_fixed[j] >= 0) ? 16'(held_fixed[j]) : 16'(p);
      r.last_of_run = (j + 1 == held_count);
      r.overflowed  = lost_flag;
      pending_probs = {pending_probs, r};
    end
    held_count = 0;
    peak_score = -16'sd32768;
    lost_flag  = 1'b0;
    vectors_sent++;
  endtask

  // Present one item and hold it until the block takes it.
  task automatic send_item(input smx_in_t item, input int fixed_prob);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= item;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    predict_softmax(item, fixed_prob);
  endtask

  task automatic send_random_vector(input int len, input int spread);
    smx_in_t item;
    int base;
    base = $urandom_range(65535) - 32768;
    for (int j = 0; j < len; j++) begin
      if (spread == 0) item.score = 16'($urandom);
      else item.score = 16'(base + int'($urandom_range(2 * spread)) - spread);
      item.final_element = (j == len - 1);
      send_item(item, -1);
    end
  endtask

  // Results: compare against the oldest pending probability.
  always @(posedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < receiver_idle_pct);
    if (rst_ni && out_valid_o && !out_stall_i) begin
      probs_seen++;
      if (pending_probs.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %p", out_data_o);
      end else begin
        if (out_data_o !== pending_probs[0]) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected %p got %p", pending_probs[0], out_data_o);
        end
        void'(pending_probs.pop_front());
      end
    end
  end

  stim_row_t directed[] = '{
    '{16'sd0, 1'b1, 65535},           // single element gets all the mass
    '{16'sd32767, 1'b1, 65535},       // largest score alone
    '{-16'sd32768, 1'b1, 65535},      // smallest score alone
    '{16'sd100, 1'b0, -1},            // two equal scores split evenly
    '{16'sd100, 1'b1, -1},
    '{-16'sd32768, 1'b0, 0},          // extreme spread: tiny side vanishes
    '{16'sd32767, 1'b1, 65535},
    '{16'sd256, 1'b0, -1},
    '{-16'sd256, 1'b0, -1},
    '{16'sd0, 1'b0, -1},
    '{16'sh5555, 1'b0, -1},
    '{-16'sh5556, 1'b1, -1}
  };

  initial begin
    smx_in_t item;
    held_count = 0;
    peak_score = -16'sd32768;
    lost_flag = 1'b0;
    mismatches = 0;
    probs_seen = 0;
    vectors_sent = 0;
    sender_idle_pct = 0;
    receiver_idle_pct = 0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed[n]) begin
      item.score = directed[n].score;
      item.final_element = directed[n].fin;
      send_item(item, directed[n].fixed_prob);
    end
    // Store full: 66 elements, the last two (final included) are dropped.
    for (int j = 0; j < Depth + 2; j++) begin
      item.score = 16'($urandom);
      item.final_element = (j == Depth + 1);
      send_item(item, -1);
    end

    for (int phase = 0; phase < 3; phase++) begin
      sender_idle_pct   = (phase == 0) ? 28 : (phase == 1) ? 60 : 0;
      receiver_idle_pct = (phase == 0) ? 60 : (phase == 1) ? 28 : 0;
      for (int v = 0; v < 7; v++) begin
        case ($urandom_range(3))
          0: send_random_vector($urandom_range(1, 4), 0);
          1: send_random_vector($urandom_range(2, 8), 512);
          2: send_random_vector($urandom_range(2, 12), 4096);
          default: send_random_vector($urandom_range(1, 6), 64);
        endcase
      end
    end
    in_valid_i <= 1'b0;

    while (pending_probs.size() != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
    $display("Covered %0d vectors and %0d probabilities, including overflow and extremes.",
             vectors_sent, probs_seen);
    if (mismatches == 0 && pending_probs.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule

[files.f]
design/smx_pkg.sv
design/smx_exp.sv
design/smx_ln.sv
design/softmax_vector_unit.sv
tb/tb_softmax_vector_unit.sv
